@@ hdl/mm3_pkg.sv @@
package mm3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  count;
    logic        full;
    logic        last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic finalising;
  } back_stat_t;

endpackage

@@ hdl/mm3_front.sv @@
module mm3_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [31:0]   data_word_i,
  input  logic [2:0]    byte_count_i,
  input  logic          last_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output mm3_pkg::item_t item_o
);

  mm3_pkg::item_t s1_q, s1_d, s2_q, s2_d;
  logic           v1_q, v2_q;
  logic           en1, en2;
  logic [2:0]     cnt;
  logic [31:0]    masked;
  logic [31:0]    rot;

  assign en2 = !v2_q || !fifo_full_i;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;
  assign push_o = v2_q && !fifo_full_i;
  assign item_o = s2_q;

  always_comb begin
    if (!last_i || byte_count_i > mm3_pkg::FULL_BYTES) begin
      cnt = mm3_pkg::FULL_BYTES;
    end else begin
      cnt = byte_count_i;
    end
    unique case (cnt)
      3'd0:    masked = 32'h0;
      3'd1:    masked = {24'h0, data_word_i[7:0]};
      3'd2:    masked = {16'h0, data_word_i[15:0]};
      3'd3:    masked = {8'h0, data_word_i[23:0]};
      default: masked = data_word_i;
    endcase
    s1_d.k     = masked * mm3_pkg::C1;
    s1_d.count = cnt;
    s1_d.full  = (cnt == mm3_pkg::FULL_BYTES);
    s1_d.last  = last_i;

    rot     = {s1_q.k[16:0], s1_q.k[31:17]};
    s2_d    = s1_q;
    s2_d.k  = rot * mm3_pkg::C2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

endmodule

@@ hdl/mm3_fifo.sv @@
module mm3_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mm3_pkg::item_t      item_i,
  input  logic                pop_i,
  output mm3_pkg::item_t      item_o,
  output mm3_pkg::fifo_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mm3_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  fill_q;
  logic           do_push, do_pop;

  assign stat_o.full  = (fill_q == CW'(DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

@@ hdl/mm3_back.sv @@
module mm3_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_i,
  input  mm3_pkg::item_t      item_i,
  input  logic                item_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         hash_value_o,
  output mm3_pkg::back_stat_t stat_o
);

  typedef enum logic [1:0] {
    S_MIX,
    S_F1,
    S_F2,
    S_FIN
  } state_e;

  state_e      state_q;
  logic [31:0] hash_q, bytes_q, f_q, out_q;
  logic        start_q, out_valid_q;
  logic [31:0] h_in, bytes_d, x, r, h_d, fin0, f13;

  assign pop_o = (state_q == S_MIX) && item_valid_i;
  assign out_valid_o = out_valid_q;
  assign hash_value_o = out_q;
  assign stat_o.finalising = (state_q != S_MIX);

  always_comb begin
    h_in    = start_q ? seed_i : hash_q;
    bytes_d = (start_q ? 32'h0 : bytes_q) + 32'(item_i.count);
    x       = h_in ^ item_i.k;
    r       = {x[18:0], x[31:19]};
    h_d     = item_i.full ? (r + {r[29:0], 2'b00} + mm3_pkg::MIX_ADD) : x;
    fin0    = h_d ^ bytes_d;
    f13     = f_q ^ {13'h0, f_q[31:13]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_MIX;
      hash_q      <= '0;
      bytes_q     <= '0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
      f_q         <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_MIX: begin
          if (pop_o) begin
            if (item_i.last) begin
              f_q     <= fin0 ^ {16'h0, fin0[31:16]};
              hash_q  <= '0;
              bytes_q <= '0;
              start_q <= 1'b1;
              state_q <= S_F1;
            end else begin
              hash_q  <= h_d;
              bytes_q <= bytes_d;
              start_q <= 1'b0;
            end
          end
        end
        S_F1: begin
          f_q     <= f_q * mm3_pkg::F1;
          state_q <= S_F2;
        end
        S_F2: begin
          f_q     <= f13 * mm3_pkg::F2;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= f_q ^ {16'h0, f_q[31:16]};
            out_valid_q <= 1'b1;
            state_q     <= S_MIX;
          end
        end
        default: state_q <= S_MIX;
      endcase
    end
  end

endmodule

@@ hdl/murmur3_hash_32.sv @@
// path: front stages s1, s2, queue, back states S_MIX, S_F1, S_F2, S_FIN
// throughput: one word per cycle while the queue has room; message ends hold
// the mixer for the finaliser multiplies; the front stages keep filling the queue
// reset: asynchronous active low; clears pipeline, queue, running hash and
// the seed register (seed 0), and arms the block for a new message
module murmur3_hash_32 #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]         seed_q;
  logic                push, pop;
  mm3_pkg::item_t      front_item, head_item;
  mm3_pkg::fifo_stat_t fifo_stat;
  mm3_pkg::back_stat_t back_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_data_i;
    end
  end

  mm3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .fifo_full_i  (fifo_stat.full),
    .push_o       (push),
    .item_o       (front_item)
  );

  mm3_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (fifo_stat)
  );

  mm3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .item_i       (head_item),
    .item_valid_i (!fifo_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o),
    .stat_o       (back_stat)
  );

`ifndef SYNTHESIS
  a_fifo_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue full and empty at once");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_stat.finalising))
    else $error("result raised without finalising");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.finalising |-> !pop)
    else $error("queue popped while finalising");
`endif

endmodule

@@ test/murmur3_hash_32_checker.sv @@
module murmur3_hash_32_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] hash_value_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam logic [31:0] LANE_MUL_A = 32'hcc9e2d51;
  localparam logic [31:0] LANE_MUL_B = 32'h1b873593;
  localparam logic [31:0] STEP_ADD   = 32'he6546b64;
  localparam logic [31:0] FMIX_MUL_A = 32'h85ebca6b;
  localparam logic [31:0] FMIX_MUL_B = 32'hc2b2ae35;
  localparam int          LANE_ROT   = 15;
  localparam int          STEP_ROT   = 13;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  logic [31:0] seed_q;
  logic [31:0] running_hash;
  logic [31:0] byte_total;
  logic        fresh_message;
  logic [31:0] expected_hashes[$];
  int          mismatch_count = 0;

  initial begin
    mismatches_o = 0;
    pending_o = 0;
  end

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_lane(input logic [31:0] k);
    logic [31:0] t;
    t = k * LANE_MUL_A;
    t = rotate_left(t, LANE_ROT);
    return t * LANE_MUL_B;
  endfunction

  function automatic logic [31:0] absorb_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ scramble_lane(k);
    t = rotate_left(t, STEP_ROT);
    return t * 32'd5 + STEP_ADD;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FMIX_MUL_A;
    t = t ^ (t >> 13);
    t = t * FMIX_MUL_B;
    return t ^ (t >> 16);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic take_request(input logic [31:0] word, input logic [2:0] count,
                              input logic fin);
    logic [31:0] h;
    logic [31:0] keep;
    logic [2:0]  n;
    if (fresh_message) begin
      running_hash = seed_q;
      byte_total = '0;
      fresh_message = 1'b0;
    end
    h = running_hash;
    n = (!fin || count > WORD_BYTES) ? WORD_BYTES : count;
    if (n == WORD_BYTES) begin
      h = absorb_block(h, word);
    end else begin
      // partial tail: upper bytes masked, no rotate/multiply step
      keep = (n == 3'd0) ? 32'h0 : (32'hffffffff >> (32 - 8 * int'(n)));
      h = h ^ scramble_lane(word & keep);
    end
    byte_total = byte_total + 32'(n);
    if (fin) begin
      h = h ^ byte_total;
      expected_hashes.push_back(avalanche(h));
      running_hash = '0;
      byte_total = '0;
      fresh_message = 1'b1;
    end else begin
      running_hash = h;
    end
  endtask

  task automatic check_hash(input logic [31:0] got);
    logic [31:0] want;
    if (expected_hashes.size() == 0) begin
      report_mismatch($sformatf("hash_value %h with no request waiting", got));
    end else begin
      want = expected_hashes.pop_front();
      if (got !== want)
        report_mismatch($sformatf("hash_value %h, expected %h", got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q = '0;
      running_hash = '0;
      byte_total = '0;
      fresh_message = 1'b1;
      expected_hashes.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        take_request(data_word_i, byte_count_i, last_i);
      if (out_valid_i && !out_stall_i)
        check_hash(hash_value_i);
      if (cfg_valid_i && cfg_ready_i)
        seed_q = cfg_data_i;
      pending_o <= expected_hashes.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

@@ test/murmur3_hash_32_tb.sv @@
module murmur3_hash_32_tb;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_WORDS    = 210;
  localparam int CALM_WORDS     = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] hash_value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  int mismatch_total;
  int pending_hashes;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;

  murmur3_hash_32 uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  murmur3_hash_32_checker check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_i (hash_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatch_total),
    .pending_o    (pending_hashes)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // hash receiver back-pressure
  initial begin
    wait (rst_ni);
    forever begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
      if (!calm && $urandom_range(99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(17, 1)) @(posedge clk_i);
      end
    end
  end

  task automatic push_word(input logic [31:0] word, input logic [2:0] count,
                           input logic fin);
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_word_i <= word;
    byte_count_i <= count;
    last_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_message(input int words);
    logic [2:0] count;
    for (int i = 0; i < words - 1; i++) begin
      // byte count on inner words is ignored, so vary it now and then
      count = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
      push_word($urandom, count, 1'b0);
    end
    push_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic random_phase(input int budget);
    int sent;
    int words;
    sent = 0;
    while (sent < budget) begin
      words = ($urandom_range(15) == 0) ? $urandom_range(60, 17) : $urandom_range(6, 1);
      send_message(words);
      sent += words;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    stall_pct = 30;
    // reset seed of zero
    push_word(32'hffffffff, 3'd0, 1'b1);
    push_word(32'hffffffff, 3'd1, 1'b1);
    push_word(32'hffffffff, 3'd2, 1'b1);
    push_word(32'hffffffff, 3'd3, 1'b1);
    push_word(32'hffffffff, 3'd4, 1'b1);
    push_word(32'h00000000, 3'd4, 1'b1);
    push_word(32'hffffffff, 3'd5, 1'b1);
    push_word(32'hffffffff, 3'd6, 1'b1);
    push_word(32'hffffffff, 3'd7, 1'b1);
    push_word(32'h00000000, 3'd0, 1'b0);
    push_word(32'hffffffff, 3'd7, 1'b0);
    push_word(32'h80000001, 3'd3, 1'b1);
    drain();
    write_seed(32'hffffffff);
    push_word(32'hffffffff, 3'd4, 1'b0);
    push_word(32'h00000000, 3'd1, 1'b1);
    push_word(32'h00000000, 3'd0, 1'b1);
    // seed change inside a message only applies to the next one
    push_word(32'h12345678, 3'd4, 1'b0);
    drain();
    write_seed(32'h80000000);
    push_word(32'h9abcdef0, 3'd2, 1'b1);
    push_word(32'h7fffffff, 3'd4, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: write_seed(32'h00000000);
        1: write_seed(32'hffffffff);
        default: write_seed($urandom);
      endcase
      idle_pct = (p == 2) ? 0 : $urandom_range(60);
      stall_pct = (p == 2) ? 0 : $urandom_range(80);
      random_phase(PHASE_WORDS);
    end

    drain();
    calm = 1'b1;
    write_seed($urandom);
    random_phase(CALM_WORDS);

    drain();
    if (mismatch_total == 0 && pending_hashes == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mm3_pkg.sv
hdl/mm3_front.sv
hdl/mm3_fifo.sv
hdl/mm3_back.sv
hdl/murmur3_hash_32.sv
test/murmur3_hash_32_checker.sv
test/murmur3_hash_32_tb.sv
